FILE: hw/rtl/ntfsrl_pkg.sv
// Package for the NTFS run-list decoder.
// Holds phase and status codes, the result control struct and default sizes.
// No dependencies.
package ntfsrl_pkg;

    localparam int CLUSTER_BITS_DEF    = 48;
    localparam int MAX_FIELD_BYTES_DEF = 7;
    localparam int NUM_CLUSTERS_W      = 48;
    localparam int DATA_W              = 8;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef struct packed {
        logic    emit;
        t_status status;
        logic    list_end;
    } t_res_ctl;

endpackage

FILE: hw/rtl/ntfsrl_decode.sv
// Run-list decode state and per-byte next-state logic.
// Holds phase, counters, accumulators and the cluster pointer; one byte per step.
// Depends on ntfsrl_pkg.
module ntfsrl_decode #(
    parameter int CLUSTER_BITS    = ntfsrl_pkg::CLUSTER_BITS_DEF,
    parameter int MAX_FIELD_BYTES = ntfsrl_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_step,
    input  logic [ntfsrl_pkg::DATA_W-1:0]         i_data_byte,
    input  logic                                  i_first_byte,
    input  logic                                  i_last_byte,
    input  logic [ntfsrl_pkg::NUM_CLUSTERS_W-1:0] i_num_clusters,
    output ntfsrl_pkg::t_res_ctl                  o_ctl,
    output logic [CLUSTER_BITS-1:0]               o_run_cluster,
    output logic [MAX_FIELD_BYTES*8-1:0]          o_run_length
);

    localparam int FB    = MAX_FIELD_BYTES * 8;
    localparam int POS_W = $clog2(MAX_FIELD_BYTES);
    localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);
    localparam int MAXW  = (FB > CLUSTER_BITS) ? FB : CLUSTER_BITS;
    localparam int SW    = ((MAXW > ntfsrl_pkg::NUM_CLUSTERS_W) ?
                            MAXW : ntfsrl_pkg::NUM_CLUSTERS_W) + 2;

    ntfsrl_pkg::t_phase      r_phase, n_phase;
    logic [CNT_W-1:0]        r_len_left, n_len_left;
    logic [CNT_W-1:0]        r_off_left, n_off_left;
    logic [CNT_W-1:0]        r_off_size, n_off_size;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [FB-1:0]           r_len_acc, n_len_acc;
    logic [FB-1:0]           r_off_acc, n_off_acc;
    logic [CLUSTER_BITS-1:0] r_ptr, n_ptr;
    logic                    r_finished, n_finished;

    logic [3:0]    w_nl;
    logic [3:0]    w_no;
    logic [FB-1:0] w_lane_mask;
    logic          w_neg;
    logic [SW-1:0] w_sum;
    logic          w_range_fail;

    always_comb begin
        w_nl = i_data_byte[3:0];
        w_no = i_data_byte[7:4];

        n_phase    = i_first_byte ? ntfsrl_pkg::PH_HEADER : r_phase;
        n_len_left = i_first_byte ? '0 : r_len_left;
        n_off_left = i_first_byte ? '0 : r_off_left;
        n_off_size = i_first_byte ? '0 : r_off_size;
        n_pos      = i_first_byte ? '0 : r_pos;
        n_len_acc  = i_first_byte ? '0 : r_len_acc;
        n_off_acc  = i_first_byte ? '0 : r_off_acc;
        n_ptr      = i_first_byte ? '0 : r_ptr;
        n_finished = i_first_byte ? 1'b0 : r_finished;

        o_ctl         = '{emit: 1'b0, status: ntfsrl_pkg::ST_RUN, list_end: 1'b0};
        o_run_cluster = '0;
        o_run_length  = '0;
        w_lane_mask   = '0;
        w_neg         = 1'b0;
        w_sum         = '0;
        w_range_fail  = 1'b0;

        if (!n_finished) begin
            case (n_phase)
                ntfsrl_pkg::PH_LENGTH: begin
                    for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
                        if (n_pos == POS_W'(k)) begin
                            n_len_acc[k*8 +: 8] = n_len_acc[k*8 +: 8] | i_data_byte;
                        end
                    end
                    n_pos      = n_pos + 1'b1;
                    n_len_left = n_len_left - 1'b1;
                    if (n_len_left == '0) begin
                        n_phase = ntfsrl_pkg::PH_OFFSET;
                        n_pos   = '0;
                    end
                    if (i_last_byte) begin
                        n_phase    = ntfsrl_pkg::PH_HEADER;
                        n_finished = 1'b1;
                        o_ctl = '{emit: 1'b1, status: ntfsrl_pkg::ST_FAIL, list_end: 1'b1};
                    end
                end
                ntfsrl_pkg::PH_OFFSET: begin
                    for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
                        if (n_pos == POS_W'(k)) begin
                            n_off_acc[k*8 +: 8] = n_off_acc[k*8 +: 8] | i_data_byte;
                        end
                    end
                    n_pos      = n_pos + 1'b1;
                    n_off_left = n_off_left - 1'b1;
                    // sign extension from the top byte of the field
                    for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
                        if (CNT_W'(k) < n_off_size || k == 0) begin
                            w_lane_mask[k*8 +: 8] = 8'hff;
                        end
                        if ((CNT_W'(k + 1) == n_off_size) ||
                            (k == 0 && n_off_size == '0)) begin
                            w_neg = n_off_acc[k*8 + 7];
                        end
                    end
                    w_sum = {{(SW-CLUSTER_BITS){1'b0}}, n_ptr} +
                            {{(SW-FB){w_neg}},
                             (n_off_acc & w_lane_mask) | (w_neg ? ~w_lane_mask : '0)};
                    w_range_fail = w_sum[SW-1] ||
                        (w_sum > {{(SW-ntfsrl_pkg::NUM_CLUSTERS_W){1'b0}}, i_num_clusters});
                    if (n_off_left != '0) begin
                        if (i_last_byte) begin
                            n_phase    = ntfsrl_pkg::PH_HEADER;
                            n_finished = 1'b1;
                            o_ctl = '{emit: 1'b1, status: ntfsrl_pkg::ST_FAIL,
                                      list_end: 1'b1};
                        end
                    end else if (w_range_fail || i_last_byte) begin
                        n_phase    = ntfsrl_pkg::PH_HEADER;
                        n_finished = 1'b1;
                        o_ctl = '{emit: 1'b1, status: ntfsrl_pkg::ST_FAIL, list_end: 1'b1};
                    end else begin
                        n_ptr         = w_sum[CLUSTER_BITS-1:0];
                        n_phase       = ntfsrl_pkg::PH_HEADER;
                        n_pos         = '0;
                        o_ctl         = '{emit: 1'b1, status: ntfsrl_pkg::ST_RUN,
                                          list_end: 1'b0};
                        o_run_cluster = w_sum[CLUSTER_BITS-1:0];
                        o_run_length  = n_len_acc;
                    end
                end
                default: begin
                    if (i_data_byte == '0) begin
                        n_phase    = ntfsrl_pkg::PH_HEADER;
                        n_finished = 1'b1;
                        o_ctl = '{emit: 1'b1, status: ntfsrl_pkg::ST_DONE, list_end: 1'b1};
                    end else if (w_no == '0 || w_nl > 4'(MAX_FIELD_BYTES) ||
                                 w_no > 4'(MAX_FIELD_BYTES) || i_last_byte) begin
                        n_phase    = ntfsrl_pkg::PH_HEADER;
                        n_finished = 1'b1;
                        o_ctl = '{emit: 1'b1, status: ntfsrl_pkg::ST_FAIL, list_end: 1'b1};
                    end else begin
                        n_len_left = w_nl[CNT_W-1:0];
                        n_off_left = w_no[CNT_W-1:0];
                        n_off_size = w_no[CNT_W-1:0];
                        n_pos      = '0;
                        n_len_acc  = '0;
                        n_off_acc  = '0;
                        n_phase    = (w_nl != '0) ? ntfsrl_pkg::PH_LENGTH
                                                  : ntfsrl_pkg::PH_OFFSET;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ntfsrl_pkg::PH_HEADER;
            r_len_left <= '0;
            r_off_left <= '0;
            r_off_size <= '0;
            r_pos      <= '0;
            r_len_acc  <= '0;
            r_off_acc  <= '0;
            r_ptr      <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_off_size <= n_off_size;
            r_pos      <= n_pos;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_ptr      <= n_ptr;
            r_finished <= n_finished;
        end
    end

endmodule

FILE: hw/rtl/ntfs_runlist_decoder_core.sv
// NTFS data-run list decoder, top level.
// Input register, decode step, result register. Depends on ntfsrl_pkg, ntfsrl_decode.
// A request's result (if any) reaches the outputs via the input and result registers.
// Throughput: one byte per cycle unless the output stalls; a stall holds the decode step.
// Reset (synchronous, active low) clears all decode state and num_clusters to zero.
module ntfs_runlist_decoder_core #(
    parameter int CLUSTER_BITS    = ntfsrl_pkg::CLUSTER_BITS_DEF,
    parameter int MAX_FIELD_BYTES = ntfsrl_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ntfsrl_pkg::NUM_CLUSTERS_W-1:0] i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [ntfsrl_pkg::DATA_W-1:0]         i_data_byte,
    input  logic                                  i_first_byte,
    input  logic                                  i_last_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_status,
    output logic [CLUSTER_BITS-1:0]               o_run_cluster,
    output logic [MAX_FIELD_BYTES*8-1:0]          o_run_length,
    output logic                                  o_list_end
);

    logic [ntfsrl_pkg::NUM_CLUSTERS_W-1:0] r_num_clusters;

    logic                          r_in_valid;
    logic [ntfsrl_pkg::DATA_W-1:0] r_byte;
    logic                          r_first;
    logic                          r_last;

    logic                          r_out_valid;
    ntfsrl_pkg::t_status           r_status;
    logic [CLUSTER_BITS-1:0]       r_cluster;
    logic [MAX_FIELD_BYTES*8-1:0]  r_length;
    logic                          r_list_end;

    logic                          w_out_free;
    logic                          w_step;
    logic                          w_accept;
    ntfsrl_pkg::t_res_ctl          w_ctl;
    logic [CLUSTER_BITS-1:0]       w_cluster;
    logic [MAX_FIELD_BYTES*8-1:0]  w_length;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_clusters <= '0;
        end else if (i_cfg_we) begin
            r_num_clusters <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte  <= i_data_byte;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
    end

    ntfsrl_decode #(
        .CLUSTER_BITS    (CLUSTER_BITS),
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_data_byte    (r_byte),
        .i_first_byte   (r_first),
        .i_last_byte    (r_last),
        .i_num_clusters (r_num_clusters),
        .o_ctl          (w_ctl),
        .o_run_cluster  (w_cluster),
        .o_run_length   (w_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_ctl.emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_ctl.emit) begin
            r_status   <= w_ctl.status;
            r_cluster  <= w_cluster;
            r_length   <= w_length;
            r_list_end <= w_ctl.list_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_run_cluster = r_cluster;
    assign o_run_length  = r_length;
    assign o_list_end    = r_list_end;

endmodule
